[src/mf3_pkg.sv]
// Shared types and fixed constants of the 3x3 median filter.
// No dependencies; used by the interfaces, the median unit and the top level.
`default_nettype none

package mf3_pkg;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // Result field widths and frame limits.
    localparam int ROW_BITS   = 12;
    localparam int COL_BITS   = 5;
    localparam int MAX_HEIGHT = 4096;

    // Window size and the rank of the median inside it.
    localparam int WIN_SIZE    = 9;
    localparam int MEDIAN_RANK = 4;

    // Bookkeeping that travels with a window through the median unit.
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
        logic                eof;
    } t_meta;

    // Next slot of the three-slot circular row store.
    function automatic logic [1:0] lane_inc(input logic [1:0] lane);
        logic [1:0] nxt;
        nxt = (lane == 2'd2) ? 2'd0 : lane + 2'd1;
        return nxt;
    endfunction

endpackage

`default_nettype wire

[src/mf3_if.sv]
// Valid/ready channel interfaces of the median filter: pixel in, result out, configuration.
// Depends on mf3_pkg for field widths.
`default_nettype none

interface mf3_pix_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mf3_res_if #(
    parameter int PIXEL_BITS = 16
);
    logic                              valid;
    logic                              ready;
    logic signed [PIXEL_BITS-1:0]      median_value;
    logic [mf3_pkg::ROW_BITS-1:0]      out_row;
    logic [mf3_pkg::COL_BITS-1:0]      out_column;
    logic                              last_of_run;
    logic                              end_of_frame;

    modport source (output valid, output median_value, output out_row, output out_column,
                    output last_of_run, output end_of_frame, input ready);
    modport sink   (input valid, input median_value, input out_row, input out_column,
                    input last_of_run, input end_of_frame, output ready);
endinterface

interface mf3_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mf3_pkg::CFG_IDX_BITS-1:0]   index;
    logic [mf3_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/mf3_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module mf3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/mf3_median.sv]
// Two-stage median-of-nine unit with its own output register and valid/ready flow.
// Depends on mf3_pkg for the window size, median rank and result bookkeeping type.
`default_nettype none

module mf3_median #(
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_vld,
    output logic                                           o_rdy,
    input  wire logic [mf3_pkg::WIN_SIZE*PIXEL_BITS-1:0]   i_win,
    input  wire mf3_pkg::t_meta                            i_meta,
    output logic                                           o_vld,
    input  wire logic                                      i_rdy,
    output logic signed [PIXEL_BITS-1:0]                   o_med,
    output logic [mf3_pkg::ROW_BITS-1:0]                   o_row,
    output logic [mf3_pkg::COL_BITS-1:0]                   o_col,
    output logic                                           o_last,
    output logic                                           o_eof
);

    localparam int N = mf3_pkg::WIN_SIZE;

    logic signed [PIXEL_BITS-1:0] win_v   [N];
    logic [N-1:0]                 below   [N];
    logic                         r_s1_vld;
    logic signed [PIXEL_BITS-1:0] r_s1_v  [N];
    logic [N-1:0]                 r_below [N];
    mf3_pkg::t_meta               r_s1_meta;
    logic [3:0]                   rank    [N];
    logic signed [PIXEL_BITS-1:0] sel_med;
    logic                         en_out;
    logic                         r_o_vld;

    // Pipeline advance: the output register frees up when empty or taken.
    assign en_out = !r_o_vld || i_rdy;
    assign o_rdy  = !r_s1_vld || en_out;
    assign o_vld  = r_o_vld;

    // Stage one: compare every pair; ties are broken by window position.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            win_v[i] = $signed(i_win[i*PIXEL_BITS +: PIXEL_BITS]);
        end
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                if (j < i) begin
                    below[i][j] = (win_v[j] <= win_v[i]);
                end else begin
                    below[i][j] = (win_v[j] < win_v[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_rdy) begin
            r_s1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_s1_v    <= win_v;
            r_below   <= below;
            r_s1_meta <= i_meta;
        end
    end

    // Stage two: the value with exactly MEDIAN_RANK smaller entries is the median.
    always_comb begin
        sel_med = '0;
        for (int i = 0; i < N; i++) begin
            rank[i] = '0;
            for (int j = 0; j < N; j++) begin
                rank[i] = rank[i] + 4'(r_below[i][j]);
            end
            if (rank[i] == 4'(mf3_pkg::MEDIAN_RANK)) begin
                sel_med = sel_med | r_s1_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en_out) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s1_vld) begin
            o_med  <= sel_med;
            o_row  <= r_s1_meta.row;
            o_col  <= r_s1_meta.col;
            o_last <= r_s1_meta.last;
            o_eof  <= r_s1_meta.eof;
        end
    end

endmodule

`default_nettype wire

[src/median_filter_3x3_zero_pad_unit.sv]
// 3x3 median filter with zero padding over a raster-order pixel stream. Each pixel is
// written into a row store that keeps three rows, one column per entry, by a
// read-modify-write, and the result for the pixel up and to the left of it is then
// emitted; the last pixel of a row also emits the row above's last result and the last
// pixel of the frame emits the whole final row. A new pixel is accepted only once the
// sequencer is idle again after the previous one, paced by the row store's single read
// port and the sequencer that issues at most one window per cycle to the two-stage median
// unit; the frame's last pixel adds a flush that rereads every column. Each window passes
// through the median unit's stage-one register and output register, and a full output
// register lets the sequencer stall. The row store has no clearing pass after reset. Width
// and height writes restart the frame; configuration writes are meant only while the block is idle.
// Depends on mf3_pkg, mf3_if, mf3_ram and mf3_median.
`default_nettype none

module median_filter_3x3_zero_pad_unit #(
    parameter int MAX_WIDTH  = 32,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mf3_pix_if.sink    i_pix,
    mf3_res_if.source  o_res,
    mf3_cfg_if.sink    i_cfg
);

    localparam int PB    = PIXEL_BITS;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int FW    = $clog2(MAX_WIDTH + 1);
    localparam int RB    = mf3_pkg::ROW_BITS;
    localparam int W_RST = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_COL      = 3'd1;
    localparam logic [2:0] S_RES_A    = 3'd2;
    localparam logic [2:0] S_RES_B    = 3'd3;
    localparam logic [2:0] S_FL_START = 3'd4;
    localparam logic [2:0] S_FL_SHIFT = 3'd5;
    localparam logic [2:0] S_FL_RES   = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [AW-1:0]        r_col, n_col;
    logic [RB-1:0]        r_row, n_row;
    logic [1:0]           r_sel, n_sel;
    logic [AW-1:0]        r_wm1;
    logic [RB-1:0]        r_hm1;
    logic signed [PB-1:0] r_px, n_px;
    logic [AW-1:0]        r_cur_c, n_cur_c;
    logic [RB-1:0]        r_cur_r, n_cur_r;
    logic [1:0]           r_lane, n_lane;
    logic                 r_need_a, n_need_a;
    logic                 r_need_b, n_need_b;
    logic                 r_flush, n_flush;
    logic [FW-1:0]        r_fl_rd, n_fl_rd;
    logic signed [PB-1:0] r_win_top [3], n_win_top [3];
    logic signed [PB-1:0] r_win_mid [3], n_win_mid [3];
    logic signed [PB-1:0] r_win_bot [3], n_win_bot [3];

    logic                 pix_xfer;
    logic                 cfg_xfer;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic                 ram_wr_en;
    logic [3*PB-1:0]      ram_wr_data;
    logic [3*PB-1:0]      ram_rd_data;
    logic [1:0]           lane_r2;
    logic [1:0]           lane_r1;
    logic signed [PB-1:0] px_r2, px_r1, px_r0;
    logic signed [PB-1:0] nc_top, nc_mid;
    logic signed [PB-1:0] fc_top, fc_mid;
    logic                 fl_zero;
    logic                 fl_last;
    logic [AW-1:0]        col_m1;
    logic [FW-1:0]        fl_k;
    logic [9*PB-1:0]      win_a, win_b;
    logic                 seq_vld;
    logic                 med_rdy;
    logic [9*PB-1:0]      seq_win;
    mf3_pkg::t_meta       seq_meta;
    logic [5:0]           cfg_w;
    logic [12:0]          cfg_h;

    assign pix_xfer    = i_pix.valid && i_pix.ready;
    assign cfg_xfer    = i_cfg.valid && i_cfg.ready;
    assign i_pix.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Row store: entry c holds column c of the three most recent rows.
    mf3_ram #(
        .WIDTH (3 * PB),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_cur_c),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Slot selection: the current row sits in r_lane, older rows follow it cyclically.
    assign lane_r2 = mf3_pkg::lane_inc(r_lane);
    assign lane_r1 = mf3_pkg::lane_inc(lane_r2);

    always_comb begin
        case (lane_r2)
            2'd0:    px_r2 = $signed(ram_rd_data[0*PB +: PB]);
            2'd1:    px_r2 = $signed(ram_rd_data[1*PB +: PB]);
            2'd2:    px_r2 = $signed(ram_rd_data[2*PB +: PB]);
            default: px_r2 = '0;
        endcase
        case (lane_r1)
            2'd0:    px_r1 = $signed(ram_rd_data[0*PB +: PB]);
            2'd1:    px_r1 = $signed(ram_rd_data[1*PB +: PB]);
            2'd2:    px_r1 = $signed(ram_rd_data[2*PB +: PB]);
            default: px_r1 = '0;
        endcase
        case (r_lane)
            2'd0:    px_r0 = $signed(ram_rd_data[0*PB +: PB]);
            2'd1:    px_r0 = $signed(ram_rd_data[1*PB +: PB]);
            2'd2:    px_r0 = $signed(ram_rd_data[2*PB +: PB]);
            default: px_r0 = '0;
        endcase
    end

    // Write-back data: the new pixel replaces the current row's slot.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_lane == 2'(i)) begin
                ram_wr_data[i*PB +: PB] = r_px;
            end else begin
                ram_wr_data[i*PB +: PB] = ram_rd_data[i*PB +: PB];
            end
        end
    end

    // Column entering the window on a pixel: rows above the frame read as zero.
    assign nc_top = (r_cur_r >= RB'(2)) ? px_r2 : '0;
    assign nc_mid = (r_cur_r >= RB'(1)) ? px_r1 : '0;

    // Column entering the window during the final-row flush; the row below is padding.
    assign fl_zero = (r_fl_rd > FW'(r_wm1));
    assign fc_top  = (fl_zero || r_cur_r == '0) ? '0 : px_r1;
    assign fc_mid  = fl_zero ? '0 : px_r0;
    assign fl_last = (r_fl_rd == FW'(r_wm1) + FW'(1));
    assign col_m1  = r_cur_c - AW'(1);
    assign fl_k    = r_fl_rd - FW'(1);

    // Windows: full three columns, or the right edge with a padding column.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            win_a[(0+j)*PB +: PB] = r_win_top[j];
            win_a[(3+j)*PB +: PB] = r_win_mid[j];
            win_a[(6+j)*PB +: PB] = r_win_bot[j];
        end
        for (int j = 0; j < 2; j++) begin
            win_b[(0+j)*PB +: PB] = r_win_top[j+1];
            win_b[(3+j)*PB +: PB] = r_win_mid[j+1];
            win_b[(6+j)*PB +: PB] = r_win_bot[j+1];
        end
        win_b[2*PB +: PB] = '0;
        win_b[5*PB +: PB] = '0;
        win_b[8*PB +: PB] = '0;
    end

    // Sequencer: accept, read-modify-write, issue results, then flush the last row.
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_sel       = r_sel;
        n_px        = r_px;
        n_cur_c     = r_cur_c;
        n_cur_r     = r_cur_r;
        n_lane      = r_lane;
        n_need_a    = r_need_a;
        n_need_b    = r_need_b;
        n_flush     = r_flush;
        n_fl_rd     = r_fl_rd;
        n_win_top   = r_win_top;
        n_win_mid   = r_win_mid;
        n_win_bot   = r_win_bot;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_col;
        ram_wr_en   = 1'b0;
        seq_vld     = 1'b0;
        seq_win     = win_a;
        seq_meta    = '0;

        case (r_state)
            S_IDLE: begin
                if (pix_xfer) begin
                    ram_rd_en = 1'b1;
                    n_px      = i_pix.pixel_value;
                    n_cur_c   = r_col;
                    n_cur_r   = r_row;
                    n_lane    = r_sel;
                    n_need_a  = (r_row != '0) && (r_col != '0);
                    n_need_b  = (r_row != '0) && (r_col == r_wm1);
                    n_flush   = (r_row == r_hm1) && (r_col == r_wm1);
                    if (r_col == r_wm1) begin
                        n_col = '0;
                        if (r_row == r_hm1) begin
                            n_row = '0;
                            n_sel = 2'd0;
                        end else begin
                            n_row = r_row + RB'(1);
                            n_sel = mf3_pkg::lane_inc(r_sel);
                        end
                    end else begin
                        n_col = r_col + AW'(1);
                    end
                    n_state = S_COL;
                end
            end
            S_COL: begin
                ram_wr_en = 1'b1;
                if (r_cur_c == '0) begin
                    n_win_top[0] = '0;
                    n_win_mid[0] = '0;
                    n_win_bot[0] = '0;
                    n_win_top[1] = '0;
                    n_win_mid[1] = '0;
                    n_win_bot[1] = '0;
                end else begin
                    n_win_top[0] = r_win_top[1];
                    n_win_mid[0] = r_win_mid[1];
                    n_win_bot[0] = r_win_bot[1];
                    n_win_top[1] = r_win_top[2];
                    n_win_mid[1] = r_win_mid[2];
                    n_win_bot[1] = r_win_bot[2];
                end
                n_win_top[2] = nc_top;
                n_win_mid[2] = nc_mid;
                n_win_bot[2] = r_px;
                n_state      = S_RES_A;
            end
            S_RES_A: begin
                seq_vld       = r_need_a;
                seq_win       = win_a;
                seq_meta.row  = r_cur_r - RB'(1);
                seq_meta.col  = mf3_pkg::COL_BITS'(col_m1);
                seq_meta.last = !r_need_b && !r_flush;
                seq_meta.eof  = 1'b0;
                if (!r_need_a || med_rdy) begin
                    n_state = S_RES_B;
                end
            end
            S_RES_B: begin
                seq_vld       = r_need_b;
                seq_win       = win_b;
                seq_meta.row  = r_cur_r - RB'(1);
                seq_meta.col  = mf3_pkg::COL_BITS'(r_wm1);
                seq_meta.last = !r_flush;
                seq_meta.eof  = 1'b0;
                if (!r_need_b || med_rdy) begin
                    n_state = r_flush ? S_FL_START : S_IDLE;
                end
            end
            S_FL_START: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                n_fl_rd     = '0;
                for (int j = 0; j < 3; j++) begin
                    n_win_top[j] = '0;
                    n_win_mid[j] = '0;
                    n_win_bot[j] = '0;
                end
                n_state = S_FL_SHIFT;
            end
            S_FL_SHIFT: begin
                n_win_top[0] = r_win_top[1];
                n_win_mid[0] = r_win_mid[1];
                n_win_bot[0] = r_win_bot[1];
                n_win_top[1] = r_win_top[2];
                n_win_mid[1] = r_win_mid[2];
                n_win_bot[1] = r_win_bot[2];
                n_win_top[2] = fc_top;
                n_win_mid[2] = fc_mid;
                n_win_bot[2] = '0;
                if (r_fl_rd == '0) begin
                    // Second column still to load before the first window is complete.
                    ram_rd_en   = (r_wm1 != '0);
                    ram_rd_addr = AW'(1);
                    n_fl_rd     = FW'(1);
                end else begin
                    n_state = S_FL_RES;
                end
            end
            S_FL_RES: begin
                seq_vld       = 1'b1;
                seq_win       = win_a;
                seq_meta.row  = r_cur_r;
                seq_meta.col  = mf3_pkg::COL_BITS'(fl_k);
                seq_meta.last = fl_last;
                seq_meta.eof  = fl_last;
                if (med_rdy) begin
                    if (fl_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_rd_en   = (FW'(r_wm1) > r_fl_rd);
                        ram_rd_addr = AW'(r_fl_rd + FW'(1));
                        n_fl_rd     = r_fl_rd + FW'(1);
                        n_state     = S_FL_SHIFT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration value fields; they are clamped into their legal ranges when written.
    assign cfg_w = i_cfg.data[5:0];
    assign cfg_h = i_cfg.data[12:0];

    // Control state, configuration and frame position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_sel   <= 2'd0;
            r_wm1   <= AW'(W_RST - 1);
            r_hm1   <= RB'(31);
        end else begin
            r_state <= n_state;
            if (cfg_xfer && i_cfg.index == mf3_pkg::CFG_FRAME_WIDTH) begin
                if (cfg_w == '0) begin
                    r_wm1 <= '0;
                end else if (cfg_w > 6'(MAX_WIDTH)) begin
                    r_wm1 <= AW'(MAX_WIDTH - 1);
                end else begin
                    r_wm1 <= AW'(cfg_w - 6'd1);
                end
            end
            if (cfg_xfer && i_cfg.index == mf3_pkg::CFG_FRAME_HEIGHT) begin
                if (cfg_h == '0) begin
                    r_hm1 <= '0;
                end else if (cfg_h > 13'(mf3_pkg::MAX_HEIGHT)) begin
                    r_hm1 <= RB'(mf3_pkg::MAX_HEIGHT - 1);
                end else begin
                    r_hm1 <= RB'(cfg_h - 13'd1);
                end
            end
            // A register write restarts the frame.
            if (cfg_xfer && (i_cfg.index == mf3_pkg::CFG_FRAME_WIDTH ||
                             i_cfg.index == mf3_pkg::CFG_FRAME_HEIGHT)) begin
                r_col <= '0;
                r_row <= '0;
                r_sel <= 2'd0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
                r_sel <= n_sel;
            end
        end
    end

    // Per-pixel working registers and the window.
    always_ff @(posedge i_clk) begin
        r_px      <= n_px;
        r_cur_c   <= n_cur_c;
        r_cur_r   <= n_cur_r;
        r_lane    <= n_lane;
        r_need_a  <= n_need_a;
        r_need_b  <= n_need_b;
        r_flush   <= n_flush;
        r_fl_rd   <= n_fl_rd;
        r_win_top <= n_win_top;
        r_win_mid <= n_win_mid;
        r_win_bot <= n_win_bot;
    end

    // Median unit; its output register drives the result channel.
    mf3_median #(
        .PIXEL_BITS (PB)
    ) u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (seq_vld),
        .o_rdy   (med_rdy),
        .i_win   (seq_win),
        .i_meta  (seq_meta),
        .o_vld   (o_res.valid),
        .i_rdy   (o_res.ready),
        .o_med   (o_res.median_value),
        .o_row   (o_res.out_row),
        .o_col   (o_res.out_column),
        .o_last  (o_res.last_of_run),
        .o_eof   (o_res.end_of_frame)
    );

`ifndef ASSERT_OFF
    // The column position never runs past the configured row length.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_wm1)
        else $error("column counter beyond frame width");

    // The row-store slot pointer stays within the three slots.
    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel != 2'd3)
        else $error("row slot pointer out of range");

    // The frame's last result always closes its run.
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.end_of_frame) |-> o_res.last_of_run)
        else $error("end of frame without last of run");

    // Windows are issued only from the result states of the sequencer.
    a_issue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_vld |-> (r_state == S_RES_A || r_state == S_RES_B || r_state == S_FL_RES))
        else $error("window issued outside a result state");
`endif

endmodule

`default_nettype wire

[dv/median_filter_3x3_zero_pad_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for the 3x3 zero-padded median filter: it streams frames of several
// sizes, predicts every median window, and compares results in order. Depends on mf3_pkg,
// mf3_if and median_filter_3x3_zero_pad_unit.

// One filtered pixel as it leaves the block.
typedef struct packed {
    logic signed [15:0]            median;
    logic [mf3_pkg::ROW_BITS-1:0]  row;
    logic [mf3_pkg::COL_BITS-1:0]  col;
    logic                          last;
    logic                          eof;
} t_median_result;

// Tracks the frame position and the three newest rows, and holds the medians still owed.
class median_tracker;
    localparam int MAX_COLS = 32;

    int             pixels[3][MAX_COLS];
    bit [5:0]       width_reg;
    bit [12:0]      height_reg;
    int             row_ctr;
    int             col_ctr;
    int             newest;
    t_median_result expected_medians[$];
    int             errors;

    function new();
        foreach (pixels[i, j]) pixels[i][j] = 0;
        width_reg  = 6'd32;
        height_reg = 13'd32;
        row_ctr    = 0;
        col_ctr    = 0;
        newest     = 0;
        errors     = 0;
    endfunction

    // A write to a known register restarts the frame; the row store keeps its contents.
    function void write_register(logic [mf3_pkg::CFG_IDX_BITS-1:0] idx,
                                 logic [mf3_pkg::CFG_DATA_BITS-1:0] data);
        if (idx == mf3_pkg::CFG_FRAME_WIDTH) begin
            width_reg = data[5:0];
        end else if (idx == mf3_pkg::CFG_FRAME_HEIGHT) begin
            height_reg = data;
        end else begin
            return;
        end
        row_ctr = 0;
        col_ctr = 0;
        newest  = 0;
    endfunction

    // Pixel at (rr,cc) of the current frame, zero outside the frame or the kept rows.
    function int tap(int rr, int cc, int w, int h);
        int d;
        if (rr < 0 || rr >= h || cc < 0 || cc >= w) return 0;
        d = row_ctr - rr;
        if (d < 0 || d > 2) return 0;
        return pixels[(newest + 3 - d) % 3][cc];
    endfunction

    // Fifth smallest of the nine window values centered on (r,c).
    function int window_median(int r, int c, int w, int h);
        int v[9];
        int n;
        int x;
        int j;
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                v[n] = tap(r + dr, c + dc, w, h);
                n++;
            end
        end
        for (int i = 1; i < 9; i++) begin
            x = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > x) begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = x;
        end
        return v[mf3_pkg::MEDIAN_RANK];
    endfunction

    function void owe_median(int r, int c, int w, int h, bit eof);
        t_median_result res;
        int med;
        med        = window_median(r, c, w, h);
        res.median = med[15:0];
        res.row    = r[mf3_pkg::ROW_BITS-1:0];
        res.col    = c[mf3_pkg::COL_BITS-1:0];
        res.last   = 1'b0;
        res.eof    = eof;
        expected_medians.push_back(res);
    endfunction

    // Store an accepted pixel and queue every median that it completes.
    function void note_pixel(logic signed [15:0] px);
        int w;
        int h;
        int r;
        int c;
        int first;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg));
        h = (height_reg == 0) ? 1 :
            ((height_reg > mf3_pkg::MAX_HEIGHT) ? mf3_pkg::MAX_HEIGHT : int'(height_reg));
        r = row_ctr;
        c = col_ctr;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        row_ctr = r;
        first = expected_medians.size();
        pixels[newest][c] = px;

        if (r >= 1 && c >= 1) owe_median(r - 1, c - 1, w, h, 1'b0);
        if (r >= 1 && c == w - 1) owe_median(r - 1, w - 1, w, h, 1'b0);
        // The frame's last pixel flushes the whole final row.
        if (r == h - 1 && c == w - 1) begin
            for (int k = 0; k < w; k++) owe_median(r, k, w, h, k == w - 1);
        end
        if (expected_medians.size() > first) expected_medians[$].last = 1'b1;

        // Advance the raster position.
        if (c == w - 1) begin
            col_ctr = 0;
            if (r == h - 1) begin
                row_ctr = 0;
                newest  = 0;
            end else begin
                row_ctr = r + 1;
                newest  = (newest + 1) % 3;
            end
        end else begin
            col_ctr = c + 1;
        end
    endfunction

    // Compare one delivered result with the oldest owed median.
    function void check_result(t_median_result got);
        t_median_result want;
        if (expected_medians.size() == 0) begin
            $error("result with nothing expected: median_value %0d row %0d column %0d",
                   got.median, got.row, got.col);
            errors++;
            return;
        end
        want = expected_medians.pop_front();
        if (got.median !== want.median) begin
            $error("median_value: expected %0d, actual %0d", want.median, got.median);
            errors++;
        end
        if (got.row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, got.row);
            errors++;
        end
        if (got.col !== want.col) begin
            $error("out_column: expected %0d, actual %0d", want.col, got.col);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, got.last);
            errors++;
        end
        if (got.eof !== want.eof) begin
            $error("end_of_frame: expected %0b, actual %0b", want.eof, got.eof);
            errors++;
        end
    endfunction
endclass

module median_filter_3x3_zero_pad_unit_test;

    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_PIXELS = 380;
    localparam int TALL_PIXELS   = 60;
    localparam logic [mf3_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [mf3_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    logic i_clk;
    logic i_rst_n;

    mf3_pix_if #(.PIXEL_BITS(16)) pix_bus ();
    mf3_res_if #(.PIXEL_BITS(16)) res_bus ();
    mf3_cfg_if                    cfg_bus ();

    median_tracker tracker = new();
    bit            steady;
    int            random_pixels;

    median_filter_3x3_zero_pad_unit #(
        .MAX_WIDTH  (32),
        .PIXEL_BITS (16)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("** median_filter_3x3_zero_pad_unit: FAILED **");
        $finish;
    end

    // Result sink: ready drops now and then unless a steady stretch is running.
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_bus.ready = steady || ($urandom_range(99) >= 10);
        end
    end

    // Observe every transfer on the three channels.
    always @(posedge i_clk) begin
        t_median_result got;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                tracker.write_register(cfg_bus.index, cfg_bus.data);
            end
            if (pix_bus.valid && pix_bus.ready) begin
                tracker.note_pixel(pix_bus.pixel_value);
            end
            if (res_bus.valid && res_bus.ready) begin
                got.median = res_bus.median_value;
                got.row    = res_bus.out_row;
                got.col    = res_bus.out_column;
                got.last   = res_bus.last_of_run;
                got.eof    = res_bus.end_of_frame;
                tracker.check_result(got);
            end
        end
    end

    task automatic send_pixel(input logic signed [15:0] value);
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < 10) begin
            pix_bus.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        pix_bus.valid       = 1'b1;
        pix_bus.pixel_value = value;
        do @(posedge i_clk); while (!pix_bus.ready);
    endtask

    task automatic end_pixels();
        @(negedge i_clk);
        pix_bus.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [mf3_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [mf3_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Wait until every owed median has arrived, then let the block go quiet.
    task automatic settle();
        while (tracker.expected_medians.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly random pixels, with extremes and small values to force ties.
    function automatic logic signed [15:0] pick_pixel();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2, 3:    return 16'(int'($urandom_range(8)) - 4);
            default: return raw[15:0];
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_pixel(pick_pixel());
        end_pixels();
    endtask

    initial begin
        int w;
        int h;
        int eff_w;
        int eff_h;
        int frame_len;
        int count;
        int split;
        logic [mf3_pkg::CFG_DATA_BITS-1:0] cfg_word;
        logic signed [15:0] corner_set[9];

        pix_bus.valid       = 1'b0;
        pix_bus.pixel_value = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = mf3_pkg::CFG_FRAME_WIDTH;
        cfg_bus.data        = '0;
        steady              = 1'b0;
        random_pixels       = 0;
        i_rst_n             = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry of 32x32: a little over two rows.
        send_random(70);
        random_pixels += 70;
        settle();

        // Small 3x3 frame built from the value extremes.
        write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'd3);
        write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd3);
        corner_set = '{16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd32767,
                       16'sd32767, -16'sd32768, -16'sd32768, 16'sd1};
        foreach (corner_set[i]) send_pixel(corner_set[i]);
        end_pixels();
        settle();

        // Zero in both registers acts as a single-pixel frame; spare indexes change nothing.
        write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'd0);
        write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd0);
        send_pixel(-16'sd32768);
        end_pixels();
        settle();
        write_reg(CFG_SPARE_LO, 13'h1FFF);
        write_reg(CFG_SPARE_HI, 13'h0AAA);
        send_pixel(16'sd32767);
        end_pixels();
        settle();

        // Single row: the flush still covers every column.
        write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'd4);
        write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd1);
        send_pixel(16'sd5);
        send_pixel(-16'sd7);
        send_pixel(16'sd32767);
        send_pixel(-16'sd32768);
        end_pixels();
        settle();

        // Single column, with a spare-index write in the middle of the frame.
        write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'd1);
        write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd3);
        send_pixel(-16'sd3);
        end_pixels();
        settle();
        write_reg(CFG_SPARE_HI, 13'h1555);
        send_pixel(16'sd9);
        send_pixel(-16'sd1);
        end_pixels();
        settle();

        // A tall single-column frame, asked for as an oversized height, with no idling.
        steady = 1'b1;
        write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'd1);
        write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);
        send_random(TALL_PIXELS);
        settle();
        steady = 1'b0;

        // Random geometries, mostly whole frames with a few broken ones.
        while (random_pixels < RANDOM_PIXELS) begin
            steady = ($urandom_range(4) == 0);
            case ($urandom_range(9))
                0:       w = 32;
                1:       w = 0;
                2:       w = $urandom_range(33, 63);
                3:       w = 1;
                default: w = $urandom_range(2, 8);
            endcase
            case ($urandom_range(9))
                0:       h = 0;
                1:       h = mf3_pkg::MAX_HEIGHT;
                2:       h = $urandom_range(mf3_pkg::MAX_HEIGHT + 1, 8191);
                3:       h = 1;
                default: h = $urandom_range(2, 6);
            endcase
            eff_w = (w == 0) ? 1 : ((w > 32) ? 32 : w);
            eff_h = (h == 0) ? 1 : ((h > mf3_pkg::MAX_HEIGHT) ? mf3_pkg::MAX_HEIGHT : h);
            frame_len = eff_w * eff_h;

            // Upper data bits of a width write are don't-care; exercise them.
            cfg_word = 13'($urandom());
            cfg_word[5:0] = w[5:0];
            if ($urandom_range(1) == 0) cfg_word[12:6] = '0;
            if ($urandom_range(1) == 0) begin
                write_reg(mf3_pkg::CFG_FRAME_WIDTH, cfg_word);
                write_reg(mf3_pkg::CFG_FRAME_HEIGHT, h[12:0]);
            end else begin
                write_reg(mf3_pkg::CFG_FRAME_HEIGHT, h[12:0]);
                write_reg(mf3_pkg::CFG_FRAME_WIDTH, cfg_word);
            end

            if (frame_len > 200) begin
                count = 3 * eff_w + $urandom_range(eff_w);
            end else if ($urandom_range(5) == 0) begin
                count = $urandom_range(1, frame_len);
            end else begin
                count = frame_len * $urandom_range(1, 2);
            end
            if (count > RANDOM_PIXELS - random_pixels) begin
                count = RANDOM_PIXELS - random_pixels;
            end

            // Now and then pause mid-stream for a spare-index write.
            if (count > 1 && $urandom_range(7) == 0) begin
                split = $urandom_range(1, count - 1);
                send_random(split);
                settle();
                write_reg(($urandom_range(1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          13'($urandom()));
                send_random(count - split);
            end else begin
                send_random(count);
            end
            random_pixels += count;
            settle();
        end

        steady = 1'b0;
        settle();
        if (tracker.errors == 0 && tracker.expected_medians.size() == 0) begin
            $display("** median_filter_3x3_zero_pad_unit: PASSED **");
        end else begin
            $display("** median_filter_3x3_zero_pad_unit: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
src/mf3_pkg.sv
src/mf3_if.sv
src/mf3_ram.sv
src/mf3_median.sv
src/median_filter_3x3_zero_pad_unit.sv
dv/median_filter_3x3_zero_pad_unit_test.sv
